### hw/rtl/srclex_pkg.sv
// ----------------------------------------------------------------------------
// srclex_pkg
// Shared codes, token kinds and byte-class helpers for the source lexer.
// ----------------------------------------------------------------------------
package srclex_pkg;

  localparam int unsigned OFFSET_WIDTH_DEF = 24;
  localparam int unsigned KIND_WIDTH       = 7;
  localparam int unsigned MODE_WIDTH       = 5;

  // Lexer modes.
  localparam logic [4:0] MODE_IDLE  = 5'd0;
  localparam logic [4:0] MODE_IDENT = 5'd1;
  localparam logic [4:0] MODE_NUM   = 5'd2;
  localparam logic [4:0] MODE_STR   = 5'd3;
  localparam logic [4:0] MODE_CHO   = 5'd4;
  localparam logic [4:0] MODE_CHE   = 5'd5;
  localparam logic [4:0] MODE_CHB   = 5'd6;
  localparam logic [4:0] MODE_LCMT  = 5'd7;
  localparam logic [4:0] MODE_BCMT  = 5'd8;
  localparam logic [4:0] MODE_BSTAR = 5'd9;
  localparam logic [4:0] MODE_SHR   = 5'd10;
  localparam logic [4:0] MODE_SHL   = 5'd11;
  localparam logic [4:0] MODE_OP    = 5'd12;
  localparam logic [4:0] MODE_OPEND = 5'd25;

  // Operator leader indexes, counted from the first leader in the single-character list.
  localparam logic [3:0] LEAD_GT    = 4'd0;
  localparam logic [3:0] LEAD_LT    = 4'd1;
  localparam logic [3:0] LEAD_SLASH = 4'd9;

  // Token kinds.
  localparam logic [6:0] K_FIRST_LEAD = 7'd10;
  localparam logic [6:0] K_SHR    = 7'd25;
  localparam logic [6:0] K_SHRE   = 7'd26;
  localparam logic [6:0] K_SHL    = 7'd28;
  localparam logic [6:0] K_SHLE   = 7'd29;
  localparam logic [6:0] K_DOTDOT = 7'd47;
  localparam logic [6:0] K_IDENT  = 7'd58;
  localparam logic [6:0] K_INT    = 7'd59;
  localparam logic [6:0] K_FLOAT  = 7'd60;
  localparam logic [6:0] K_CHAR   = 7'd61;
  localparam logic [6:0] K_BOOL   = 7'd62;
  localparam logic [6:0] K_STRING = 7'd63;
  localparam logic [6:0] K_EOS    = 7'd64;
  localparam logic [6:0] K_ERROR  = 7'd65;
  localparam logic [6:0] K_BAD    = 7'd66;

  // Index into the single-character list; 24 means the byte is not in it.
  localparam logic [4:0] SC_NONE = 5'd24;
  localparam logic [4:0] SC_FIRST_LEAD = 5'd10;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    return (b >= 8'h20) && (b <= 8'h7f);
  endfunction

  function automatic logic [4:0] sc_index(input logic [7:0] b);
    logic [4:0] r;
    case (b)
      "(": r = 5'd0;   ")": r = 5'd1;   "[": r = 5'd2;   "]": r = 5'd3;
      "{": r = 5'd4;   "}": r = 5'd5;   "#": r = 5'd6;   "~": r = 5'd7;
      ";": r = 5'd8;   ",": r = 5'd9;   ">": r = 5'd10;  "<": r = 5'd11;
      "!": r = 5'd12;  "=": r = 5'd13;  "|": r = 5'd14;  "^": r = 5'd15;
      "&": r = 5'd16;  "+": r = 5'd17;  "-": r = 5'd18;  "/": r = 5'd19;
      "%": r = 5'd20;  "*": r = 5'd21;  ":": r = 5'd22;  ".": r = 5'd23;
      default: r = SC_NONE;
    endcase
    return r;
  endfunction

  // Plain two-byte operators: returns {hit, kind}.
  function automatic logic [7:0] op_follow(input logic [3:0] i, input logic [7:0] b);
    logic [7:0] r;
    r = 8'd0;
    case (i)
      4'd0:  if (b == "=") r = {1'b1, 7'd24};
      4'd1:  if (b == "=") r = {1'b1, 7'd27};
      4'd2:  if (b == "=") r = {1'b1, 7'd30};
      4'd3:  if (b == "=") r = {1'b1, 7'd31};
      4'd4:  if (b == "=") r = {1'b1, 7'd32}; else if (b == "|") r = {1'b1, 7'd33};
      4'd5:  if (b == "=") r = {1'b1, 7'd34};
      4'd6:  if (b == "=") r = {1'b1, 7'd35}; else if (b == "&") r = {1'b1, 7'd36};
      4'd7:  if (b == "=") r = {1'b1, 7'd37}; else if (b == "+") r = {1'b1, 7'd38};
      4'd8:  begin
        if (b == "=") r = {1'b1, 7'd39};
        else if (b == ">") r = {1'b1, 7'd40};
        else if (b == "-") r = {1'b1, 7'd41};
      end
      4'd9:  if (b == "=") r = {1'b1, 7'd42};
      4'd10: if (b == "=") r = {1'b1, 7'd43};
      4'd11: if (b == "=") r = {1'b1, 7'd44};
      4'd12: if (b == ":") r = {1'b1, 7'd45}; else if (b == "=") r = {1'b1, 7'd46};
      4'd13: if (b == ".") r = {1'b1, K_DOTDOT};
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Keyword lookup on the packed word buffer, last byte lowest.
  function automatic logic [6:0] word_kind(input logic [63:0] w, input logic [3:0] len);
    logic [6:0] r;
    r = K_IDENT;
    if (len == 4'd2 && w == 64'h6966) r = 7'd48;
    if (len == 4'd4 && w == 64'h656c7365) r = 7'd49;
    if (len == 4'd5 && w == 64'h7768696c65) r = 7'd50;
    if (len == 4'd3 && w == 64'h666f72) r = 7'd51;
    if (len == 4'd5 && w == 64'h756e696f6e) r = 7'd52;
    if (len == 4'd6 && w == 64'h737472756374) r = 7'd53;
    if (len == 4'd4 && w == 64'h656e756d) r = 7'd54;
    if (len == 4'd8 && w == 64'h636f6e74696e7565) r = 7'd55;
    if (len == 4'd5 && w == 64'h627265616b) r = 7'd56;
    if (len == 4'd6 && w == 64'h72657475726e) r = 7'd57;
    if (len == 4'd4 && w == 64'h74727565) r = K_BOOL;
    if (len == 4'd5 && w == 64'h66616c7365) r = K_BOOL;
    return r;
  endfunction

endpackage

### hw/rtl/source_lexer.sv
// ----------------------------------------------------------------------------
// source_lexer
// Streaming tokenizer: source bytes in, token kind and start offset out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the queue has room; its tokens
// (none, one or two) are written into a four-entry output queue in the same
// cycle. The input is ready whenever the queue has room for two words, which
// the queue depth sets. Tokens wait on at most one byte of lookahead, except
// that an integer followed by a dot waits for the byte after the dot.
module source_lexer import srclex_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: text_byte [7:0]
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,   // end_of_text
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  // tdata: tok_kind [6:0], token_offset [OFFSET_WIDTH+6:7], zero padding above
  output logic [((KIND_WIDTH+OFFSET_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic       m_axis_tlast,   // last_of_run
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready
);

  localparam int unsigned W    = OFFSET_WIDTH;
  localparam int unsigned EW   = KIND_WIDTH + W + 1;
  localparam int unsigned TDW  = ((KIND_WIDTH + OFFSET_WIDTH + 7) / 8) * 8;

  logic [MODE_WIDTH-1:0] mode_q, mode_d;
  logic [W-1:0] ts_q, ts_d, off_q, off_d;
  logic [63:0] wb_q, wb_d;
  logic [3:0]  wl_q, wl_d;
  logic        sd_q, sd_d, dp_q, dp_d;

  logic [6:0]   rk [2];
  logic [W-1:0] ro [2];
  logic [1:0]   n;
  logic         restart, accept;
  logic [7:0]   b;
  logic [3:0]   lead;
  logic [7:0]   fol;
  logic [4:0]   sci;
  logic         sd_tmp;

  logic [EW-1:0] head;
  logic [2:0]    count;

  task automatic push(input logic [6:0] k, input logic [W-1:0] o);
    if (n != 2'd2) begin
      rk[n[0]] = k;
      ro[n[0]] = o;
      n = n + 2'd1;
    end
  endtask

  assign accept = s_axis_tvalid && s_axis_tready;
  assign b      = s_axis_tdata;

  // Next state and the tokens caused by the current byte.
  always_comb begin
    mode_d  = mode_q;
    ts_d    = ts_q;
    wb_d    = wb_q;
    wl_d    = wl_q;
    sd_d    = sd_q;
    dp_d    = dp_q;
    off_d   = off_q + W'(1);
    n       = 2'd0;
    rk[0]   = '0;
    rk[1]   = '0;
    ro[0]   = '0;
    ro[1]   = '0;
    restart = 1'b0;
    lead    = 4'd0;
    fol     = 8'd0;
    sci     = SC_NONE;
    sd_tmp  = sd_q;

    case (mode_q)
      MODE_IDENT: begin
        if (is_letter(b) || is_digit(b) || b == "_") begin
          if (wl_q < 4'd8) wb_d = {wb_q[55:0], b};
          if (wl_q < 4'd9) wl_d = wl_q + 4'd1;
        end else begin
          push(word_kind(wb_q, wl_q), ts_q);
          restart = 1'b1;
        end
      end
      MODE_NUM: begin
        if (dp_q && b == ".") begin
          // Number followed by a range operator.
          dp_d = 1'b0;
          push(K_INT, ts_q);
          push(K_DOTDOT, off_q - W'(1));
          mode_d = MODE_IDLE;
        end else begin
          dp_d = 1'b0;
          if (dp_q) sd_tmp = 1'b1;
          sd_d = sd_tmp;
          if (is_digit(b)) begin
            sd_d = sd_tmp;
          end else if (b == "." && !sd_tmp) begin
            dp_d = 1'b1;
          end else begin
            push(sd_tmp ? K_FLOAT : K_INT, ts_q);
            restart = 1'b1;
          end
        end
      end
      MODE_STR: begin
        if (b == "\"") begin
          push(K_STRING, ts_q);
          mode_d = MODE_IDLE;
        end
      end
      MODE_CHO: begin
        if (b == "\\") mode_d = MODE_CHE;
        else if (is_print(b) && b != "'") mode_d = MODE_CHB;
        else begin
          push(K_ERROR, ts_q);
          restart = 1'b1;
        end
      end
      MODE_CHE: begin
        if (is_print(b)) mode_d = MODE_CHB;
        else begin
          push(K_CHAR, ts_q);
          restart = 1'b1;
        end
      end
      MODE_CHB: begin
        if (b == "'") begin
          push(K_CHAR, ts_q);
          mode_d = MODE_IDLE;
        end else begin
          push(K_ERROR, ts_q);
          restart = 1'b1;
        end
      end
      MODE_LCMT: begin
        if (b == 8'h0a || b == 8'h00) mode_d = MODE_IDLE;
      end
      MODE_BCMT: begin
        if (b == "*") mode_d = MODE_BSTAR;
        else if (b == 8'h00) mode_d = MODE_IDLE;
      end
      MODE_BSTAR: begin
        if (b == "/" || b == 8'h00) mode_d = MODE_IDLE;
        else if (b != "*") mode_d = MODE_BCMT;
      end
      MODE_SHR, MODE_SHL: begin
        if (b == "=") begin
          push((mode_q == MODE_SHR) ? K_SHRE : K_SHLE, ts_q);
          mode_d = MODE_IDLE;
        end else begin
          push((mode_q == MODE_SHR) ? K_SHR : K_SHL, ts_q);
          restart = 1'b1;
        end
      end
      default: begin
        if (mode_q >= MODE_OP && mode_q <= MODE_OPEND) begin
          lead = 4'(mode_q - MODE_OP);
          fol  = op_follow(lead, b);
          if (lead == LEAD_GT && b == ">") mode_d = MODE_SHR;
          else if (lead == LEAD_LT && b == "<") mode_d = MODE_SHL;
          else if (lead == LEAD_SLASH && b == "/") mode_d = MODE_LCMT;
          else if (lead == LEAD_SLASH && b == "*") mode_d = MODE_BCMT;
          else if (fol[7]) begin
            push(fol[6:0], ts_q);
            mode_d = MODE_IDLE;
          end else begin
            push(K_FIRST_LEAD + {3'b0, lead}, ts_q);
            restart = 1'b1;
          end
        end else begin
          restart = 1'b1;
        end
      end
    endcase

    // Byte handled afresh between tokens.
    if (restart) begin
      mode_d = MODE_IDLE;
      ts_d   = off_q;
      sci    = sc_index(b);
      if (is_space(b)) begin
        mode_d = MODE_IDLE;
      end else if (b == 8'h00) begin
        push(K_EOS, off_q);
      end else if (b == "'") begin
        ts_d   = off_q + W'(1);
        mode_d = MODE_CHO;
      end else if (b == "\"") begin
        ts_d   = off_q + W'(1);
        mode_d = MODE_STR;
      end else if (is_digit(b)) begin
        sd_d   = 1'b0;
        dp_d   = 1'b0;
        mode_d = MODE_NUM;
      end else if (is_letter(b)) begin
        wb_d   = {56'd0, b};
        wl_d   = 4'd1;
        mode_d = MODE_IDENT;
      end else if (sci < SC_FIRST_LEAD) begin
        push({2'b0, sci}, off_q);
      end else if (sci != SC_NONE) begin
        mode_d = MODE_OP + (sci - SC_FIRST_LEAD);
      end else begin
        push(K_BAD, off_q);
      end
    end

    // End of text: emit the pending token and return to reset state.
    if (s_axis_tlast) begin
      case (mode_d)
        MODE_IDENT: push(word_kind(wb_d, wl_d), ts_d);
        MODE_NUM:   push((sd_d || dp_d) ? K_FLOAT : K_INT, ts_d);
        MODE_STR, MODE_CHO, MODE_CHB: push(K_ERROR, ts_d);
        MODE_CHE:   push(K_CHAR, ts_d);
        MODE_SHR:   push(K_SHR, ts_d);
        MODE_SHL:   push(K_SHL, ts_d);
        default: begin
          if (mode_d >= MODE_OP && mode_d <= MODE_OPEND)
            push(K_FIRST_LEAD + {2'b0, mode_d - MODE_OP}, ts_d);
        end
      endcase
      mode_d = MODE_IDLE;
      ts_d   = '0;
      off_d  = '0;
      wb_d   = '0;
      wl_d   = 4'd0;
      sd_d   = 1'b0;
      dp_d   = 1'b0;
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      ts_q   <= '0;
      off_q  <= '0;
      wb_q   <= '0;
      wl_q   <= 4'd0;
      sd_q   <= 1'b0;
      dp_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      ts_q   <= ts_d;
      off_q  <= off_d;
      wb_q   <= wb_d;
      wl_q   <= wl_d;
      sd_q   <= sd_d;
      dp_q   <= dp_d;
    end
  end

  // Token queue towards the master side.
  srclex_fifo #(
    .DataWidth(EW)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(accept ? n : 2'd0),
    .push0_i   ({(n == 2'd1), ro[0], rk[0]}),
    .push1_i   ({1'b1, ro[1], rk[1]}),
    .pop_i     (m_axis_tvalid && m_axis_tready),
    .head_o    (head),
    .count_o   (count)
  );

  assign s_axis_tready = (count <= 3'd2);
  assign m_axis_tvalid = (count != 3'd0);
  assign m_axis_tdata  = TDW'(head[EW-2:0]);
  assign m_axis_tlast  = head[EW-1];

  // The queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count <= 3'd4)
    else $error("token queue overfilled");

  // A byte is only taken when two words of room remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> count <= 3'd2)
    else $error("byte accepted without room for its tokens");

  // Ending the text always leaves the lexer between tokens at offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (mode_q == MODE_IDLE && off_q == '0))
    else $error("lexer state not cleared at end of text");

endmodule

### hw/rtl/srclex_fifo.sv
// ----------------------------------------------------------------------------
// srclex_fifo
// Four-entry token queue that takes up to two words per cycle and gives one.
// ----------------------------------------------------------------------------
module srclex_fifo import srclex_pkg::*; #(
  parameter int unsigned DataWidth = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_cnt_i,
  input  logic [DataWidth-1:0] push0_i,
  input  logic [DataWidth-1:0] push1_i,
  input  logic                 pop_i,
  output logic [DataWidth-1:0] head_o,
  output logic [2:0]           count_o
);

  logic [DataWidth-1:0] mem_q [4];
  logic [1:0]           wr_q, rd_q;
  logic [2:0]           cnt_q;

  // Storage writes at the tail, one or two entries.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_q + 2'd1] <= push1_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_q + push_cnt_i;
      rd_q  <= rd_q + {1'b0, pop_i};
      cnt_q <= cnt_q + {1'b0, push_cnt_i} - {2'b0, pop_i};
    end
  end

  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the source lexer. It feeds source text as bytes and
// checks every token word against a predictor that runs beside the block.
// ----------------------------------------------------------------------------
// Directed texts cover keywords, every operator, number, char, string and
// comment shape, unterminated literals and stray bytes. Random texts follow:
// mostly well-formed token sequences with random content, plus noise bytes.
// Both sides idle at random. Once the receiver holds off for a long stretch
// while the sender keeps offering bytes, and between phases the sender waits
// until every expected token has come.
module tb_top import srclex_pkg::*; ();

  localparam int unsigned OFF_W      = 24;
  localparam int unsigned TDATA_W    = ((KIND_WIDTH + OFF_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned ITEM_TARGET = 1800;

  // Follow-byte actions: none, or a move to a further mode rather than an emit.
  localparam int ACT_NONE = -1;
  localparam int ACT_SHR  = 100;
  localparam int ACT_SHL  = 101;
  localparam int ACT_LCMT = 102;
  localparam int ACT_BCMT = 103;

  // Predicts the tokens of each accepted byte and checks the output words.
  class lexer_scoreboard;
    int            mode;
    logic [23:0]   tok_start;
    logic [23:0]   byte_pos;
    logic [63:0]   word_buf;
    int            word_len;
    bit            seen_dec;
    bit            dot_wait;
    logic [6:0]    step_kind [2];
    logic [23:0]   step_off [2];
    int            step_n;
    logic [6:0]    want_kind [$];
    logic [23:0]   want_off [$];
    bit            want_last [$];
    int            errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = MODE_IDLE;
      tok_start = '0;
      byte_pos = '0;
      word_buf = '0;
      word_len = 0;
      seen_dec = 0;
      dot_wait = 0;
    endfunction

    function void put(logic [6:0] k, logic [23:0] o);
      if (step_n < 2) begin
        step_kind[step_n] = k;
        step_off[step_n] = o;
        step_n++;
      end
    endfunction

    function bit digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit blank(logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function bit printable(logic [7:0] b);
      return b >= 8'd32 && b <= 8'd127;
    endfunction

    function logic [6:0] keyword_of();
      logic [6:0] k;
      k = K_IDENT;
      if (word_len == 2 && word_buf == 64'("if")) k = 7'd48;
      if (word_len == 4 && word_buf == 64'("else")) k = 7'd49;
      if (word_len == 5 && word_buf == 64'("while")) k = 7'd50;
      if (word_len == 3 && word_buf == 64'("for")) k = 7'd51;
      if (word_len == 5 && word_buf == 64'("union")) k = 7'd52;
      if (word_len == 6 && word_buf == 64'("struct")) k = 7'd53;
      if (word_len == 4 && word_buf == 64'("enum")) k = 7'd54;
      if (word_len == 8 && word_buf == 64'("continue")) k = 7'd55;
      if (word_len == 5 && word_buf == 64'("break")) k = 7'd56;
      if (word_len == 6 && word_buf == 64'("return")) k = 7'd57;
      if (word_len == 4 && word_buf == 64'("true")) k = K_BOOL;
      if (word_len == 5 && word_buf == 64'("false")) k = K_BOOL;
      return k;
    endfunction

    // Position in the single-character list, or 24 when absent.
    function int char_index(logic [7:0] b);
      string sc;
      sc = "()[]{}#~;,><!=|^&+-/%*:.";
      for (int i = 0; i < 24; i++) if (sc[i] == b) return i;
      return 24;
    endfunction

    // What a byte does after an operator leader.
    function int op_action(int li, logic [7:0] b);
      case (li)
        0: if (b == "=") return 24; else if (b == ">") return ACT_SHR;
        1: if (b == "=") return 27; else if (b == "<") return ACT_SHL;
        2: if (b == "=") return 30;
        3: if (b == "=") return 31;
        4: if (b == "=") return 32; else if (b == "|") return 33;
        5: if (b == "=") return 34;
        6: if (b == "=") return 35; else if (b == "&") return 36;
        7: if (b == "=") return 37; else if (b == "+") return 38;
        8: if (b == "=") return 39; else if (b == ">") return 40;
           else if (b == "-") return 41;
        9: if (b == "=") return 42; else if (b == "/") return ACT_LCMT;
           else if (b == "*") return ACT_BCMT;
        10: if (b == "=") return 43;
        11: if (b == "=") return 44;
        12: if (b == ":") return 45; else if (b == "=") return 46;
        13: if (b == ".") return K_DOTDOT;
        default: ;
      endcase
      return ACT_NONE;
    endfunction

    function void start_token(logic [7:0] b, logic [23:0] pos);
      int ci;
      mode = MODE_IDLE;
      tok_start = pos;
      ci = char_index(b);
      if (blank(b)) return;
      if (b == 8'd0) put(K_EOS, pos);
      else if (b == "'") begin
        tok_start = pos + 24'd1;
        mode = MODE_CHO;
      end else if (b == "\"") begin
        tok_start = pos + 24'd1;
        mode = MODE_STR;
      end else if (digit(b)) begin
        seen_dec = 0;
        dot_wait = 0;
        mode = MODE_NUM;
      end else if (letter(b)) begin
        word_buf = 64'(b);
        word_len = 1;
        mode = MODE_IDENT;
      end else if (ci < 10) put(7'(ci), pos);
      else if (ci < 24) mode = MODE_OP + ci - 10;
      else put(K_BAD, pos);
    endfunction

    function void advance(logic [7:0] b, logic [23:0] pos);
      int act;
      case (mode)
        MODE_IDLE: start_token(b, pos);
        MODE_IDENT: begin
          if (letter(b) || digit(b) || b == "_") begin
            if (word_len < 8) word_buf = (word_buf << 8) | 64'(b);
            if (word_len < 9) word_len++;
          end else begin
            put(keyword_of(), tok_start);
            start_token(b, pos);
          end
        end
        MODE_NUM: begin
          if (dot_wait) begin
            dot_wait = 0;
            if (b == ".") begin
              put(K_INT, tok_start);
              put(K_DOTDOT, pos - 24'd1);
              mode = MODE_IDLE;
              return;
            end
            seen_dec = 1;
          end
          if (digit(b)) return;
          if (b == "." && !seen_dec) begin
            dot_wait = 1;
            return;
          end
          put(seen_dec ? K_FLOAT : K_INT, tok_start);
          start_token(b, pos);
        end
        MODE_STR: if (b == "\"") begin
          put(K_STRING, tok_start);
          mode = MODE_IDLE;
        end
        MODE_CHO: begin
          if (b == "\\") mode = MODE_CHE;
          else if (printable(b) && b != "'") mode = MODE_CHB;
          else begin
            put(K_ERROR, tok_start);
            start_token(b, pos);
          end
        end
        MODE_CHE: begin
          if (printable(b)) mode = MODE_CHB;
          else begin
            put(K_CHAR, tok_start);
            start_token(b, pos);
          end
        end
        MODE_CHB: begin
          if (b == "'") begin
            put(K_CHAR, tok_start);
            mode = MODE_IDLE;
          end else begin
            put(K_ERROR, tok_start);
            start_token(b, pos);
          end
        end
        MODE_LCMT: if (b == "\n" || b == 8'd0) mode = MODE_IDLE;
        MODE_BCMT: begin
          if (b == "*") mode = MODE_BSTAR;
          else if (b == 8'd0) mode = MODE_IDLE;
        end
        MODE_BSTAR: begin
          if (b == "/" || b == 8'd0) mode = MODE_IDLE;
          else if (b != "*") mode = MODE_BCMT;
        end
        MODE_SHR, MODE_SHL: begin
          if (b == "=") begin
            put(mode == MODE_SHR ? K_SHRE : K_SHLE, tok_start);
            mode = MODE_IDLE;
          end else begin
            put(mode == MODE_SHR ? K_SHR : K_SHL, tok_start);
            start_token(b, pos);
          end
        end
        default: begin
          act = op_action(mode - MODE_OP, b);
          if (act == ACT_SHR) mode = MODE_SHR;
          else if (act == ACT_SHL) mode = MODE_SHL;
          else if (act == ACT_LCMT) mode = MODE_LCMT;
          else if (act == ACT_BCMT) mode = MODE_BCMT;
          else if (act != ACT_NONE) begin
            put(7'(act), tok_start);
            mode = MODE_IDLE;
          end else begin
            put(7'(mode - MODE_OP + 10), tok_start);
            start_token(b, pos);
          end
        end
      endcase
    endfunction

    // Pending token at end of text.
    function void close_text();
      case (mode)
        MODE_IDENT: put(keyword_of(), tok_start);
        MODE_NUM: put((seen_dec || dot_wait) ? K_FLOAT : K_INT, tok_start);
        MODE_STR, MODE_CHO, MODE_CHB: put(K_ERROR, tok_start);
        MODE_CHE: put(K_CHAR, tok_start);
        MODE_SHR: put(K_SHR, tok_start);
        MODE_SHL: put(K_SHL, tok_start);
        default: if (mode >= MODE_OP) put(7'(mode - MODE_OP + 10), tok_start);
      endcase
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      logic [23:0] pos;
      pos = byte_pos;
      step_n = 0;
      advance(b, pos);
      byte_pos = pos + 24'd1;
      if (last) begin
        close_text();
        clear();
      end
      for (int i = 0; i < step_n; i++) begin
        want_kind.push_back(step_kind[i]);
        want_off.push_back(step_off[i]);
        want_last.push_back(i == step_n - 1);
      end
    endfunction

    function void check_token(logic [6:0] k, logic [23:0] o, bit l);
      logic [6:0]  ek;
      logic [23:0] eo;
      bit          el;
      if (want_kind.size() == 0) begin
        $display("%0t: unexpected token kind %0d offset %0d", $time, k, o);
        errors++;
        return;
      end
      ek = want_kind.pop_front();
      eo = want_off.pop_front();
      el = want_last.pop_front();
      if (k !== ek) begin
        $display("%0t: tok_kind expected %0d actual %0d", $time, ek, k);
        errors++;
      end
      if (o !== eo) begin
        $display("%0t: token_offset expected %0d actual %0d", $time, eo, o);
        errors++;
      end
      if (l !== el) begin
        $display("%0t: last_of_run expected %0d actual %0d", $time, el, l);
        errors++;
      end
    endfunction

    function int pending();
      return want_kind.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic [7:0]         s_axis_tdata;
  logic               s_axis_tlast;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;

  lexer_scoreboard token_board;
  logic [7:0]      text_q [$];
  int unsigned     bytes_sent;
  int unsigned     cycle_count;
  logic            hold_off;
  bit              steady_rx;

  source_lexer #(.OFFSET_WIDTH(OFF_W)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  // Clock and the run limit.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random ready, a steady phase, and the long hold-off.
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        token_board.check_token(m_axis_tdata[6:0], m_axis_tdata[OFF_W+6:7], m_axis_tlast);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (steady_rx) m_axis_tready <= 1'b1;
      else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        m_axis_tready <= (stall == 0);
      end
    end
  end

  // Long hold-off on the receiver once the stream is under way.
  initial begin
    hold_off = 1'b0;
    wait (bytes_sent > 400);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    token_board.note_byte(b, last);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sends the collected text, marking its final byte.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Stops offering bytes and waits until every expected token has come.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (token_board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One random fragment of source text.
  task automatic add_fragment();
    string ops [30];
    string kws [12];
    string alnum;
    string leads;
    int    n;
    ops = '{"(", ")", "[", "]", "{", "}", "#", "~", ";", ",", ">=", ">>=", "<<=",
            "!=", "==", "|=", "||", "^=", "&&", "+=", "++", "-=", "->", "--",
            "/=", "%=", "*=", "::", ":=", ".."};
    kws = '{"if", "else", "while", "for", "union", "struct", "enum", "continue",
            "break", "return", "true", "false"};
    alnum = "abcxyzeilnorstuwAZ_09";
    leads = "><!=|^&+-/%*:.";
    case ($urandom_range(0, 15))
      0, 1: add_str(kws[$urandom_range(0, 11)]);
      2: begin
        text_q.push_back($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                               : 8'("A" + $urandom_range(0, 25)));
        n = $urandom_range(0, 10);
        repeat (n) text_q.push_back(alnum[$urandom_range(0, alnum.len() - 1)]);
      end
      3: add_str(ops[$urandom_range(0, 29)]);
      4: text_q.push_back("(");
      5: add_str(leads.substr($urandom_range(0, 13), 13));
      6: begin
        n = $urandom_range(1, 4);
        repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
        case ($urandom_range(0, 3))
          0: add_str(".5");
          1: add_str("..");
          2: add_str("..7");
          default: ;
        endcase
      end
      7: begin
        text_q.push_back("'");
        case ($urandom_range(0, 3))
          0: text_q.push_back(8'($urandom_range(32, 127)));
          1: begin
            text_q.push_back("\\");
            text_q.push_back(8'($urandom_range(32, 127)));
          end
          2: begin
            text_q.push_back("\\");
            text_q.push_back(8'($urandom_range(0, 31)));
          end
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 3) != 0) text_q.push_back("'");
      end
      8: begin
        text_q.push_back("\"");
        n = $urandom_range(0, 5);
        repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
        text_q.push_back("\"");
      end
      9: begin
        add_str($urandom_range(0, 1) ? "//" : "/*");
        n = $urandom_range(0, 5);
        repeat (n) text_q.push_back($urandom_range(0, 1) ? 8'("*")
                                                          : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) add_str("*/");
        else text_q.push_back("\n");
      end
      10, 11: text_q.push_back(8'($urandom_range(0, 255)));
      12: text_q.push_back(8'd0);
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: text_q.push_back(" ");
      1: text_q.push_back(8'(8'd9 + $urandom_range(0, 4)));
      default: ;
    endcase
  endtask

  initial begin
    int frags;
    token_board = new();
    bytes_sent = 0;
    steady_rx = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed texts: keywords, operators, literal shapes, comments, strays.
    add_str("if else while for union struct enum continue break return true false ");
    add_str("continues Zq_9abcdefgh ( ) [ ] { } # ~ ; , > < ! = | ^ & + - / % * : . ");
    add_str(">= >> >>= <= << <<= != == |= || ^= &= && += ++ -= -> -- /= %= *= :: := .. ");
    add_str("1..2 1.5 1.2.3 42x 'a' '\\n' '' 'ab \"s\"");
    text_q.push_back(8'd0);
    add_str("'\\");
    text_q.push_back(8'd1);
    add_str(" // line\n/* b ** */ @ _ ");
    text_q.push_back(8'd255);
    text_q.push_back(8'd0);
    add_str("abc");
    send_text();
    add_str("\"open");
    send_text();
    add_str("'");
    send_text();
    add_str("'\\");
    send_text();
    add_str("7.");
    send_text();
    add_str("a>>");
    send_text();
    add_str("/* open");
    send_text();
    add_str("<<");
    send_text();
    wait_drained();

    // Random texts; the sender pauses now and then until all tokens are out.
    while (bytes_sent < ITEM_TARGET) begin
      frags = $urandom_range(1, 12);
      repeat (frags) add_fragment();
      if (text_q.size() == 0) text_q.push_back(" ");
      send_text();
      if ($urandom_range(0, 9) == 0) begin
        s_axis_tvalid <= 1'b0;
        steady_rx = $urandom_range(0, 1);
        wait_drained();
      end
    end

    s_axis_tvalid <= 1'b0;
    steady_rx = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (token_board.errors == 0 && token_board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/srclex_pkg.sv
hw/rtl/srclex_fifo.sv
hw/rtl/source_lexer.sv
verif/tb_top.sv
